### rtl/ins_sort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package ins_sort_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_count;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last_out;
        logic                         overflow;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic unload;
    } t_dp_cmd;

    typedef struct packed {
        logic last_entry;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/ins_sort_dp.sv
// Datapath: row of compare-and-shift cells, fill count and drop flag.
// Depends on ins_sort_pkg; driven by ins_sort_ctrl commands.
`default_nettype none

module ins_sort_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ins_sort_pkg::t_dp_cmd  i_cmd,
    input  wire ins_sort_pkg::t_data    i_value,
    output ins_sort_pkg::t_dp_sts       o_sts,
    output ins_sort_pkg::t_out_item     o_result
);
    import ins_sort_pkg::*;

    t_data  r_cell [DEPTH];
    t_data  n_cell [DEPTH];
    t_count r_count, n_count;
    logic   r_dropped, n_dropped;

    logic   gt      [DEPTH];
    logic   prev_gt [DEPTH];
    t_data  prev_cell [DEPTH];
    logic   full;

    assign full = (r_count == t_count'(DEPTH));

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (t_count'(i) < r_count) && (r_cell[i] > i_value);
        end
        prev_gt[0]   = 1'b0;
        prev_cell[0] = i_value;
        for (int i = 1; i < DEPTH; i++) begin
            prev_gt[i]   = gt[i-1];
            prev_cell[i] = r_cell[i-1];
        end
    end

    always_comb begin
        n_cell    = r_cell;
        n_count   = r_count;
        n_dropped = r_dropped;
        priority if (i_cmd.insert) begin
            if (full) begin
                n_dropped = 1'b1;
            end else begin
                n_count = r_count + t_count'(1);
                for (int i = 0; i < DEPTH; i++) begin
                    if (gt[i] || (t_count'(i) == r_count)) begin
                        n_cell[i] = prev_gt[i] ? prev_cell[i] : i_value;
                    end
                end
            end
        end else if (i_cmd.unload) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
            if (o_sts.last_entry) begin
                n_count   = '0;
                n_dropped = 1'b0;
            end else begin
                n_count = r_count - t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    assign o_sts.last_entry      = (r_count == t_count'(1));
    assign o_result.sorted_value = r_cell[0];
    assign o_result.last_out     = o_sts.last_entry;
    assign o_result.overflow     = r_dropped;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(DEPTH))
        else $error("fill count above depth");

    a_unload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.unload |-> (r_count != '0))
        else $error("unload from empty row");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.insert && full) |=> r_dropped)
        else $error("drop not recorded");

endmodule

`default_nettype wire

### rtl/ins_sort_ctrl.sv
// Controller: idle/emit state machine issuing insert and unload commands.
// Depends on ins_sort_pkg; status comes from ins_sort_dp.
`default_nettype none

module ins_sort_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_last_item,
    input  wire ins_sort_pkg::t_dp_sts i_sts,
    output ins_sort_pkg::t_dp_cmd      o_cmd,
    output logic                       o_busy,
    output logic                       o_res_valid
);
    import ins_sort_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state, n_state;
    logic accept;

    assign o_busy      = (r_state == ST_EMIT);
    assign o_res_valid = (r_state == ST_EMIT);
    assign accept      = i_start && !o_busy;

    assign o_cmd.insert = accept;
    assign o_cmd.unload = (r_state == ST_EMIT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_last_item) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.last_entry) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_sts.last_entry) |=> !o_busy)
        else $error("emission did not end after final word");

endmodule

`default_nettype wire

### rtl/insertion_sorter_core.sv
// Insertion sorter: input words enter a row of compare-and-shift cells, one per cycle
// while busy is low. Busy stays low while a list is loading.
// After the word with last_item is accepted, busy is high while the stored words
// leave the head cell, one result per cycle.
// Synchronous active-low reset clears fill count, drop flag and state; cells are not reset.
// Depends on ins_sort_pkg, ins_sort_ctrl and ins_sort_dp.
`default_nettype none

module insertion_sorter_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire ins_sort_pkg::t_in_item i_item,
    output logic                        busy,
    output logic                        o_res_valid,
    output ins_sort_pkg::t_out_item     o_result
);
    import ins_sort_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ins_sort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_item (i_item.last_item),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_res_valid (o_res_valid)
    );

    ins_sort_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_item.value),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for insertion_sorter_core: directed table, then random lists.
// Checked against table rows or a behavioral insertion-sort predictor; depends on ins_sort_pkg.
`timescale 1ns / 100ps

module testbench;
    import ins_sort_pkg::*;

    localparam t_data D_MIN       = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_data D_MAX       = ~D_MIN;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    PHASE_WORDS = 12;

    typedef struct packed {
        t_data value;
        logic  last;
        logic  typed;
        t_data want_value;
        logic  want_last;
        logic  want_ovf;
    } t_dir_row;

    localparam int DIR_ROWS = 19;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{D_MIN,   1'b1, 1'b1, D_MIN,   1'b1, 1'b0},
        '{D_MAX,   1'b1, 1'b1, D_MAX,   1'b1, 1'b0},
        '{32'sd0,  1'b1, 1'b1, 32'sd0,  1'b1, 1'b0},
        '{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b0},
        '{32'sd5,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{-32'sd3, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{D_MAX,   1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{D_MIN,   1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd5,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd0,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{-32'sd3, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd7,  1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd42, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd42, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd3,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd2,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd1,  1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{32'sd1,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
        '{-32'sd2, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_res_valid;
    t_out_item o_result;

    // predictor state: sorted row, fill count, drop flag
    t_data     sort_row [DEPTH];
    int        sort_fill;
    bit        sort_dropped;
    t_out_item list_out [$];
    t_out_item pending_sorted [$];
    t_out_item want_word;

    int idle_pct;
    int err_count;
    int cycle_count;
    int words_sent;
    int lists_done;
    int ovf_lists;
    int words_checked;

    insertion_sorter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic insert_sorted(input t_in_item w);
        int pos;
        if (sort_fill >= DEPTH) begin
            sort_dropped = 1'b1;
        end else begin
            pos = sort_fill;
            while (pos > 0 && $signed(sort_row[pos-1]) > $signed(w.value)) begin
                sort_row[pos] = sort_row[pos-1];
                pos--;
            end
            sort_row[pos] = w.value;
            sort_fill++;
        end
        if (w.last_item) begin
            for (int k = 0; k < sort_fill; k++) begin
                list_out.push_back('{sorted_value: sort_row[k],
                                     last_out:     (k == sort_fill - 1),
                                     overflow:     sort_dropped});
            end
            if (sort_dropped)
                ovf_lists++;
            lists_done++;
            sort_fill    = 0;
            sort_dropped = 1'b0;
        end
    endtask

    // present one word, hold it until accepted, then run the predictor
    task automatic send_word(input t_in_item w);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        words_sent++;
        insert_sorted(w);
    endtask

    task automatic flush_model;
        while (list_out.size() != 0)
            pending_sorted.push_back(list_out.pop_front());
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_list(input int len);
        t_in_item w;
        int       pick;
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                w.value = $urandom;
            else if (pick < 70)
                w.value = $signed($urandom_range(0, 7)) - 4;
            else if (pick < 85)
                case ($urandom_range(0, 3))
                    0: w.value = D_MIN;
                    1: w.value = D_MAX;
                    2: w.value = '0;
                    default: w.value = '1;
                endcase
            else
                w.value = {$urandom_range(0, 1) ? 8'h80 : 8'h7f, 24'($urandom)};
            w.last_item = (k == len - 1);
            send_word(w);
            flush_model();
        end
    endtask

    task automatic random_phase(input int pct);
        int start_words;
        idle_pct    = pct;
        start_words = words_sent;
        while (words_sent - start_words < PHASE_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                send_list($urandom_range(9, 20));
            else
                send_list($urandom_range(1, 8));
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected result word: sorted_value %0d",
                       $signed(o_result.sorted_value));
                err_count++;
            end else begin
                want_word = pending_sorted.pop_front();
                words_checked++;
                if (o_result.sorted_value !== want_word.sorted_value) begin
                    $error("sorted_value: expected %0d, actual %0d",
                           $signed(want_word.sorted_value), $signed(o_result.sorted_value));
                    err_count++;
                end
                if (o_result.last_out !== want_word.last_out) begin
                    $error("last_out: expected %0b, actual %0b",
                           want_word.last_out, o_result.last_out);
                    err_count++;
                end
                if (o_result.overflow !== want_word.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want_word.overflow, o_result.overflow);
                    err_count++;
                end
            end
        end
    end

    initial begin
        t_in_item w;
        int       waited;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        sort_fill     = 0;
        sort_dropped  = 1'b0;
        err_count     = 0;
        cycle_count   = 0;
        words_sent    = 0;
        lists_done    = 0;
        ovf_lists     = 0;
        words_checked = 0;
        idle_pct      = 38;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            w.value     = DIR_TABLE[r].value;
            w.last_item = DIR_TABLE[r].last;
            send_word(w);
            if (DIR_TABLE[r].typed) begin
                list_out.delete();
                pending_sorted.push_back('{sorted_value: DIR_TABLE[r].want_value,
                                           last_out:     DIR_TABLE[r].want_last,
                                           overflow:     DIR_TABLE[r].want_ovf});
            end else begin
                flush_model();
            end
        end
        drain();

        random_phase(38);
        random_phase(72);
        random_phase(0);

        // store fills, trailing words dropped including the last one
        idle_pct = 38;
        send_list(DEPTH + 3);
        send_list(2);

        drain();
        waited = 0;
        while (waited < DEPTH + 16) begin
            @(posedge i_clk);
            waited++;
        end

        $display("Sent %0d words in %0d lists (%0d with dropped words).",
                 words_sent, lists_done, ovf_lists);
        $display("Checked %0d sorted words across three sender idle settings.", words_checked);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
